### rtl/core/tpva_pkg.sv
// ----------------------------------------------------------------------------
// tpva_pkg
// Shared types and constants for the touch pad voice allocator.
// ----------------------------------------------------------------------------
package tpva_pkg;

  localparam int VOICE_COUNT = 4;
  localparam int PAD_COUNT   = 12;
  localparam int VOICE_W     = 2;
  localparam int PAD_W       = 4;
  localparam int ENG_W       = 4;
  localparam int NV_W        = 3;

  localparam logic [ENG_W-1:0] POLY_MAX = ENG_W'(3);
  localparam logic [ENG_W-1:0] PERC_MIN = ENG_W'(7);

  localparam logic REQ_TOUCH  = 1'b0;
  localparam logic REQ_ENGINE = 1'b1;

  typedef enum logic [2:0] {
    EV_ON       = 3'd0,
    EV_OFF      = 3'd1,
    EV_CLEAR    = 3'd2,
    EV_HANDOVER = 3'd3,
    EV_DONE     = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic                 req_type;
    logic [PAD_COUNT-1:0] pads_now;
    logic [PAD_COUNT-1:0] pads_before;
    logic [ENG_W-1:0]     engine_sel;
    logic [ENG_W-1:0]     old_engine;
    logic                 poly_on;
    logic [NV_W-1:0]      voices_in_use;
  } tpva_in_t;

  typedef struct packed {
    ev_kind_t             event_kind;
    logic [VOICE_W-1:0]   voice_num;
    logic [PAD_W-1:0]     pad_num;
    logic                 percussive;
    logic                 engine_changed;
    logic                 last_event;
  } tpva_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic eng;
    logic fin;
  } tpva_cmd_t;

  typedef struct packed {
    logic pad_last;
  } tpva_sts_t;

endpackage

### rtl/core/tpva_ctrl.sv
// ----------------------------------------------------------------------------
// tpva_ctrl
// Sequencer that walks a touch scan one pad per cycle or runs an engine change.
// ----------------------------------------------------------------------------
module tpva_ctrl
  import tpva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      req_type,
  input  tpva_sts_t sts,
  output tpva_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENG,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (req_type == REQ_ENGINE) ? ST_ENG : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.pad_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_ENG:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy     = busy_r;
  assign cmd.load = start && !busy_r;
  assign cmd.scan = (state_r == ST_SCAN);
  assign cmd.eng  = (state_r == ST_ENG);
  assign cmd.fin  = (state_r == ST_FIN);

`ifndef SYNTH
  a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != ST_IDLE))
    else $error("busy does not track the sequencer state");
`endif

endmodule

### rtl/core/tpva_dp.sv
// ----------------------------------------------------------------------------
// tpva_dp
// Voice table, pad walk counter and result register.
// ----------------------------------------------------------------------------
module tpva_dp
  import tpva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tpva_cmd_t cmd,
  input  tpva_in_t  in_item,
  output tpva_sts_t sts,
  output logic      out_valid,
  output tpva_out_t out_item
);

  tpva_in_t             in_r;
  logic [PAD_W-1:0]     pad_idx_r;
  logic [PAD_W-1:0]     pad_idx_nxt;
  logic [VOICE_COUNT-1:0] busy_r;
  logic [VOICE_COUNT-1:0] busy_nxt;
  logic [PAD_W-1:0]     vpad_r   [VOICE_COUNT];
  logic [PAD_W-1:0]     vpad_nxt [VOICE_COUNT];
  logic                 ov_r;
  logic                 ov_nxt;
  tpva_out_t            oi_r;
  tpva_out_t            oi_nxt;

  logic [NV_W-1:0]      nv_sat;
  logic                 cur;
  logic                 prev;
  logic                 perc;
  logic                 changed;
  logic                 was_poly;
  logic                 is_poly;
  logic                 found;
  logic [VOICE_W-1:0]   src;
  logic [PAD_W-1:0]     src_pad;

  always_comb begin
    nv_sat   = (in_r.voices_in_use > NV_W'(VOICE_COUNT)) ? NV_W'(VOICE_COUNT)
                                                         : in_r.voices_in_use;
    cur      = in_r.pads_now[pad_idx_r];
    prev     = in_r.pads_before[pad_idx_r];
    perc     = (in_r.engine_sel > PERC_MIN);
    changed  = (in_r.old_engine != in_r.engine_sel);
    was_poly = (in_r.old_engine <= POLY_MAX);
    is_poly  = (in_r.engine_sel <= POLY_MAX);

    pad_idx_nxt = pad_idx_r;
    busy_nxt    = busy_r;
    vpad_nxt    = vpad_r;
    ov_nxt      = 1'b0;
    found       = 1'b0;
    src         = '0;
    src_pad     = '0;

    oi_nxt.event_kind     = EV_DONE;
    oi_nxt.voice_num      = '0;
    oi_nxt.pad_num        = '0;
    oi_nxt.percussive     = perc;
    oi_nxt.engine_changed = 1'b0;
    oi_nxt.last_event     = 1'b0;

    if (cmd.load) begin
      pad_idx_nxt = '0;
    end

    if (cmd.scan) begin
      pad_idx_nxt = pad_idx_r + PAD_W'(1);
      if (cur && !prev) begin
        if (in_r.poly_on) begin
          for (int v = 0; v < VOICE_COUNT; v++) begin
            if (!found && (NV_W'(v) < nv_sat) && !busy_r[v]) begin
              found       = 1'b1;
              busy_nxt[v] = 1'b1;
              vpad_nxt[v] = pad_idx_r;
              oi_nxt.voice_num = VOICE_W'(v);
            end
          end
          ov_nxt = found;
        end else begin
          busy_nxt[0] = 1'b1;
          vpad_nxt[0] = pad_idx_r;
          ov_nxt      = 1'b1;
        end
        oi_nxt.event_kind = EV_ON;
        oi_nxt.pad_num    = pad_idx_r;
      end else if (!cur && prev) begin
        if (in_r.poly_on) begin
          for (int v = 0; v < VOICE_COUNT; v++) begin
            if (!found && (NV_W'(v) < nv_sat) && busy_r[v] && (vpad_r[v] == pad_idx_r)) begin
              found       = 1'b1;
              busy_nxt[v] = 1'b0;
              oi_nxt.voice_num = VOICE_W'(v);
            end
          end
          ov_nxt = found;
        end else if (busy_r[0] && (vpad_r[0] == pad_idx_r)) begin
          busy_nxt[0] = 1'b0;
          ov_nxt      = 1'b1;
        end
        oi_nxt.event_kind = EV_OFF;
        oi_nxt.pad_num    = pad_idx_r;
      end
    end

    if (cmd.eng && changed) begin
      oi_nxt.engine_changed = 1'b1;
      for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
        if (busy_r[v]) begin
          found = 1'b1;
          src   = VOICE_W'(v);
        end
      end
      src_pad = vpad_r[src];
      if (was_poly && !is_poly) begin
        busy_nxt = '0;
        ov_nxt   = 1'b1;
        if (found) begin
          busy_nxt[0]       = 1'b1;
          vpad_nxt[0]       = src_pad;
          oi_nxt.event_kind = EV_HANDOVER;
          oi_nxt.voice_num  = src;
          oi_nxt.pad_num    = src_pad;
        end else begin
          oi_nxt.event_kind = EV_CLEAR;
        end
      end else if (!was_poly && is_poly) begin
        busy_nxt          = '0;
        ov_nxt            = 1'b1;
        oi_nxt.event_kind = EV_CLEAR;
      end
    end

    if (cmd.fin) begin
      ov_nxt                = 1'b1;
      oi_nxt.event_kind     = EV_DONE;
      oi_nxt.voice_num      = '0;
      oi_nxt.pad_num        = '0;
      oi_nxt.engine_changed = (in_r.req_type == REQ_ENGINE) && changed;
      oi_nxt.last_event     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
      vpad_r <= '{default: '0};
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      vpad_r <= vpad_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    pad_idx_r <= pad_idx_nxt;
    oi_r      <= oi_nxt;
  end

  assign sts.pad_last = (pad_idx_r == PAD_W'(PAD_COUNT - 1));
  assign out_valid    = ov_r;
  assign out_item     = oi_r;

`ifndef SYNTH
  a_last_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oi_r.last_event |-> $past(cmd.fin))
    else $error("final transaction without a finish step");
  a_clear_frees_all: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (oi_r.event_kind == EV_CLEAR) |-> (busy_r == '0))
    else $error("voices still busy after all cleared");
  a_handover_voice0: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (oi_r.event_kind == EV_HANDOVER) |-> ($onehot(busy_r) && busy_r[0]))
    else $error("handover left voices other than voice 0 busy");
  a_note_on_stored: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (oi_r.event_kind == EV_ON)
      |-> (busy_r[oi_r.voice_num] && (vpad_r[oi_r.voice_num] == oi_r.pad_num)))
    else $error("note on not reflected in the voice table");
`endif

endmodule

### rtl/core/touch_pad_voice_allocator.sv
// ----------------------------------------------------------------------------
// touch_pad_voice_allocator
// Assigns pad presses and releases to voices and handles engine class changes.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     start, busy          in_item  (tpva_in_t)
// result    out_valid (strobe)   out_item (tpva_out_t)
//
// A touch scan loads the request, walks the 12 pads in turn and takes one finish
// step; the done then passes through the result register. An engine change runs
// the engine step and the finish step, and the next start is taken with the done.
// Reset clears the voice table and the sequencer; the block is ready at once.
// Each result is shown for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module touch_pad_voice_allocator
  import tpva_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  tpva_in_t  in_item,
  output logic      out_valid,
  output tpva_out_t out_item
);

  tpva_cmd_t cmd;
  tpva_sts_t sts;

  tpva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_item.req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  tpva_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### test/tb_touch_pad_voice_allocator.sv
// ----------------------------------------------------------------------------
// tb_touch_pad_voice_allocator
// Self-checking bench for the touch pad voice allocator. Directed transactions
// cover poly and mono allocation, dropped presses, unmatched releases and every
// kind of engine class change. Random touch scans and engine changes follow,
// with random gaps on the input side. A predictor keeps its own voice table,
// and every result transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb_touch_pad_voice_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import tpva_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  tpva_in_t  in_item;
  logic      out_valid;
  tpva_out_t out_item;

  logic               voice_held [VOICE_COUNT];
  logic [PAD_W-1:0]   voice_note [VOICE_COUNT];
  tpva_out_t          expected_events [$];
  int                 err_count;
  logic               no_gaps;

  touch_pad_voice_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 40) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic void push_event(input ev_kind_t kind, input int voice, input int pad,
                                     input logic perc, input logic changed,
                                     input logic last);
    tpva_out_t ev;
    ev.event_kind     = kind;
    ev.voice_num      = VOICE_W'(voice);
    ev.pad_num        = PAD_W'(pad);
    ev.percussive     = perc;
    ev.engine_changed = changed;
    ev.last_event     = last;
    expected_events.push_back(ev);
  endfunction

  function automatic void clear_voices();
    for (int v = 0; v < VOICE_COUNT; v++) begin
      voice_held[v] = 1'b0;
    end
  endfunction

  // Updates the voice table for one accepted transaction and queues its events.
  function automatic void allocate_voices(input tpva_in_t it);
    int               nv;
    int               src;
    logic             perc;
    logic             cur;
    logic             prev;
    logic             was_poly;
    logic             is_poly;
    logic [PAD_W-1:0] pad;
    nv   = (it.voices_in_use > VOICE_COUNT) ? VOICE_COUNT : int'(it.voices_in_use);
    perc = it.engine_sel > PERC_MIN;
    if (it.req_type == REQ_TOUCH) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        cur  = it.pads_now[i];
        prev = it.pads_before[i];
        if (cur && !prev) begin
          if (it.poly_on) begin
            for (int v = 0; v < nv; v++) begin
              if (!voice_held[v]) begin
                voice_held[v] = 1'b1;
                voice_note[v] = PAD_W'(i);
                push_event(EV_ON, v, i, perc, 1'b0, 1'b0);
                break;
              end
            end
          end else begin
            voice_held[0] = 1'b1;
            voice_note[0] = PAD_W'(i);
            push_event(EV_ON, 0, i, perc, 1'b0, 1'b0);
          end
        end else if (!cur && prev) begin
          if (it.poly_on) begin
            for (int v = 0; v < nv; v++) begin
              if (voice_held[v] && voice_note[v] == PAD_W'(i)) begin
                voice_held[v] = 1'b0;
                push_event(EV_OFF, v, i, perc, 1'b0, 1'b0);
                break;
              end
            end
          end else if (voice_held[0] && voice_note[0] == PAD_W'(i)) begin
            voice_held[0] = 1'b0;
            push_event(EV_OFF, 0, i, perc, 1'b0, 1'b0);
          end
        end
      end
      push_event(EV_DONE, 0, 0, perc, 1'b0, 1'b1);
    end else if (it.old_engine == it.engine_sel) begin
      push_event(EV_DONE, 0, 0, perc, 1'b0, 1'b1);
    end else begin
      was_poly = it.old_engine <= POLY_MAX;
      is_poly  = it.engine_sel <= POLY_MAX;
      if (was_poly && !is_poly) begin
        src = -1;
        for (int v = 0; v < VOICE_COUNT; v++) begin
          if (voice_held[v]) begin
            src = v;
            break;
          end
        end
        if (src >= 0) begin
          pad = voice_note[src];
          clear_voices();
          voice_held[0] = 1'b1;
          voice_note[0] = pad;
          push_event(EV_HANDOVER, src, pad, perc, 1'b1, 1'b0);
        end else begin
          clear_voices();
          push_event(EV_CLEAR, 0, 0, perc, 1'b1, 1'b0);
        end
      end else if (!was_poly && is_poly) begin
        clear_voices();
        push_event(EV_CLEAR, 0, 0, perc, 1'b1, 1'b0);
      end
      push_event(EV_DONE, 0, 0, perc, 1'b1, 1'b1);
    end
  endfunction

  always @(posedge clk) begin : check_results
    tpva_out_t want;
    if (rst_n && out_valid) begin
      if (expected_events.size() == 0) begin
        report_mismatch("result with nothing expected, event_kind",
                        int'(out_item.event_kind), -1);
      end else begin
        want = expected_events.pop_front();
        if (out_item.event_kind !== want.event_kind)
          report_mismatch("event_kind", int'(out_item.event_kind), int'(want.event_kind));
        if (out_item.voice_num !== want.voice_num)
          report_mismatch("voice_num", int'(out_item.voice_num), int'(want.voice_num));
        if (out_item.pad_num !== want.pad_num)
          report_mismatch("pad_num", int'(out_item.pad_num), int'(want.pad_num));
        if (out_item.percussive !== want.percussive)
          report_mismatch("percussive", int'(out_item.percussive), int'(want.percussive));
        if (out_item.engine_changed !== want.engine_changed)
          report_mismatch("engine_changed", int'(out_item.engine_changed),
                          int'(want.engine_changed));
        if (out_item.last_event !== want.last_event)
          report_mismatch("last_event", int'(out_item.last_event), int'(want.last_event));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tpva_in_t touch_scan(input logic [PAD_COUNT-1:0] now_bits,
                                          input logic [PAD_COUNT-1:0] before_bits,
                                          input int eng, input logic poly, input int nv);
    tpva_in_t it;
    it.req_type      = REQ_TOUCH;
    it.pads_now      = now_bits;
    it.pads_before   = before_bits;
    it.engine_sel    = ENG_W'(eng);
    it.old_engine    = ENG_W'($urandom_range(0, 15));
    it.poly_on       = poly;
    it.voices_in_use = NV_W'(nv);
    return it;
  endfunction

  function automatic tpva_in_t engine_change(input int old_eng, input int new_eng);
    tpva_in_t it;
    it.req_type      = REQ_ENGINE;
    it.pads_now      = PAD_COUNT'($urandom);
    it.pads_before   = PAD_COUNT'($urandom);
    it.engine_sel    = ENG_W'(new_eng);
    it.old_engine    = ENG_W'(old_eng);
    it.poly_on       = 1'($urandom);
    it.voices_in_use = NV_W'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic send_item(input tpva_in_t it);
    int gap;
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    allocate_voices(it);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_events.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_poly_voices();
    send_item(touch_scan(12'hFFF, 12'h000, 0, 1'b1, 4));
    send_item(touch_scan(12'h000, 12'hFFF, 0, 1'b1, 7));
    send_item(touch_scan(12'h020, 12'h000, 0, 1'b1, 0));
    send_item(touch_scan(12'h000, 12'h020, 0, 1'b1, 0));
    send_item(touch_scan(12'h003, 12'h000, 0, 1'b1, 1));
    send_item(touch_scan(12'h000, 12'h003, 0, 1'b1, 1));
  endtask

  task automatic test_mono_voice();
    send_item(touch_scan(12'h028, 12'h000, 5, 1'b0, 4));
    send_item(touch_scan(12'h020, 12'h028, 5, 1'b0, 4));
    send_item(touch_scan(12'h000, 12'h020, 5, 1'b0, 4));
  endtask

  task automatic test_engine_change();
    send_item(engine_change(1, 1));
    send_item(touch_scan(12'h044, 12'h000, 1, 1'b1, 4));
    send_item(touch_scan(12'h040, 12'h044, 1, 1'b1, 4));
    send_item(engine_change(1, 9));
    send_item(engine_change(9, 12));
    send_item(engine_change(12, 0));
    send_item(engine_change(0, 4));
    send_item(engine_change(4, 15));
    send_item(engine_change(15, 3));
    send_item(touch_scan(12'h800, 12'h000, 3, 1'b1, 4));
    send_item(engine_change(3, 7));
    send_item(touch_scan(12'h000, 12'h800, 7, 1'b0, 4));
    send_item(engine_change(7, 8));
    send_item(engine_change(8, 2));
  endtask

  task automatic test_random_traffic(input int count);
    logic [PAD_COUNT-1:0] pads_held;
    logic [PAD_COUNT-1:0] before_bits;
    logic [PAD_COUNT-1:0] flips;
    int                   cur_eng;
    int                   new_eng;
    int                   old_eng;
    int                   nv;
    int                   r;
    logic                 poly;
    pads_held = '0;
    cur_eng   = 2;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        new_eng = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(0, 15);
        old_eng = (r < 10) ? cur_eng : $urandom_range(0, 15);
        send_item(engine_change(old_eng, new_eng));
        cur_eng = new_eng;
      end else begin
        before_bits = (r < 92) ? pads_held : PAD_COUNT'($urandom);
        if ($urandom_range(0, 9) < 8) begin
          flips = '0;
          repeat ($urandom_range(1, 3)) flips[$urandom_range(0, PAD_COUNT - 1)] = 1'b1;
        end else begin
          flips = PAD_COUNT'($urandom);
        end
        poly = ($urandom_range(0, 9) == 0) ? 1'($urandom) : (cur_eng <= int'(POLY_MAX));
        nv   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(0, 7);
        send_item(touch_scan(before_bits ^ flips, before_bits, cur_eng, poly, nv));
        pads_held = before_bits ^ flips;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    int waited;
    err_count = 0;
    no_gaps   = 1'b0;
    clear_voices();
    for (int v = 0; v < VOICE_COUNT; v++) begin
      voice_note[v] = '0;
    end
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_poly_voices();
    drain_results();
    test_mono_voice();
    drain_results();
    test_engine_change();
    drain_results();
    test_random_traffic(200);

    start <= 1'b0;
    waited = 0;
    while (expected_events.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    while (expected_events.size() > 0) begin
      void'(expected_events.pop_front());
      report_mismatch("expected result never arrived, left", 0, 1);
    end
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
